[design/cbq_pkg.sv]
// cbq_pkg: shared constants for the clamped biquad cascade
// operation codes, coefficient slot codes, tap ordering and parameter defaults
// no dependencies
package cbq_pkg;

  // parameter defaults
  localparam int NUM_BANDS_DEF   = 10;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 32;

  // fixed arithmetic layout
  localparam int COEF_FRAC = 26;
  localparam int ACC_BITS  = 64;
  localparam int TAP_COUNT = 5;

  // operation codes carried in tuser
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // coefficient slots within one stage
  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  // tap order within a stage: delayed terms first, current input last
  localparam logic [2:0] SEQ_X1  = 3'd0;
  localparam logic [2:0] SEQ_X2  = 3'd1;
  localparam logic [2:0] SEQ_Y1  = 3'd2;
  localparam logic [2:0] SEQ_Y2  = 3'd3;
  localparam logic [2:0] SEQ_X0  = 3'd4;

  function automatic logic [2:0] seq_slot(input logic [2:0] seq);
    logic [2:0] slot;
    case (seq)
      SEQ_X1:  slot = SLOT_B1;
      SEQ_X2:  slot = SLOT_B2;
      SEQ_Y1:  slot = SLOT_A1;
      SEQ_Y2:  slot = SLOT_A2;
      default: slot = SLOT_B0;
    endcase
    return slot;
  endfunction

endpackage

[design/clamped_biquad_cascade.sv]
// clamped_biquad_cascade: NUM_BANDS+1 direct form I biquads in series, one shared MAC
// throughput: a filter item is taken only while idle, once the last result is in the output
//   register; coefficient writes, one per cycle, are also taken only while idle;
//   the single multiplier handles one tap of one stage per cycle
// reset: control state, output valid and per-entry valid bits clear at once, no sweep;
//   unwritten coefficients and delay rows read as zero. depends on cbq_pkg
module clamped_biquad_cascade #(
  parameter int NUM_BANDS   = cbq_pkg::NUM_BANDS_DEF,
  parameter int SAMPLE_BITS = cbq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = cbq_pkg::COEF_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // input items
  input  logic s_tvalid,
  output logic s_tready,
  // sample_in, stage_select[3:0], coef_select[2:0], coef_value[31:0], zero pad
  input  logic [((SAMPLE_BITS+46)/8)*8-1:0] s_tdata,
  // opcode
  input  logic s_tuser,
  // result items
  output logic m_tvalid,
  input  logic m_tready,
  // sample_out, zero pad
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

  localparam int NUM_STAGES = NUM_BANDS + 1;
  localparam int COEF_DEPTH = cbq_pkg::TAP_COUNT * NUM_STAGES;
  localparam int CADDR_W    = $clog2(COEF_DEPTH);
  localparam int STAGE_W    = $clog2(NUM_STAGES);
  localparam int ROW_W      = 4 * SAMPLE_BITS;
  localparam int OUT_W      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
  localparam int WIDE_W     = (PROD_W > cbq_pkg::ACC_BITS ? PROD_W : cbq_pkg::ACC_BITS) + 1;
  localparam int SUM_W      = cbq_pkg::ACC_BITS + 1;

  // accumulator saturates symmetrically at +-(2^63-1)
  localparam logic signed [cbq_pkg::ACC_BITS-1:0] ACC_MAX =
    signed'({1'b0, {(cbq_pkg::ACC_BITS-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] PROD_MAX = WIDE_W'(ACC_MAX);
  localparam logic signed [SUM_W-1:0]  SUM_MAX  = SUM_W'(ACC_MAX);
  localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) <<< (cbq_pkg::COEF_FRAC - 1);
  // output saturation range
  localparam logic signed [cbq_pkg::ACC_BITS-1:0] SMAX =
    cbq_pkg::ACC_BITS'(signed'({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
  localparam logic signed [cbq_pkg::ACC_BITS-1:0] SMIN = -SMAX - 1;
  // delay clamp at +-3/8 of full scale
  localparam logic signed [SAMPLE_BITS-1:0] CLAMP = SAMPLE_BITS'(3) <<< (SAMPLE_BITS - 4);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  function automatic logic signed [SAMPLE_BITS-1:0] clamp15(
    input logic signed [SAMPLE_BITS-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > CLAMP) begin
      r = CLAMP;
    end else if (v < -CLAMP) begin
      r = -CLAMP;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [cbq_pkg::ACC_BITS-1:0] sat_sum(
    input logic signed [SUM_W-1:0] v);
    logic signed [cbq_pkg::ACC_BITS-1:0] r;
    if (v > SUM_MAX) begin
      r = ACC_MAX;
    end else if (v < -SUM_MAX) begin
      r = -ACC_MAX;
    end else begin
      r = cbq_pkg::ACC_BITS'(v);
    end
    return r;
  endfunction

  // input field unpacking
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [3:0]                    in_stage;
  logic [2:0]                    in_slot;
  logic signed [31:0]            in_coef;
  assign in_sample = signed'(s_tdata[SAMPLE_BITS-1:0]);
  assign in_stage  = s_tdata[SAMPLE_BITS+3:SAMPLE_BITS];
  assign in_slot   = s_tdata[SAMPLE_BITS+6:SAMPLE_BITS+4];
  assign in_coef   = signed'(s_tdata[SAMPLE_BITS+38:SAMPLE_BITS+7]);

  logic [1:0] state;
  logic       in_fire;
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  // coefficient store: one write port for write items, one read port for the sequencer
  logic [COEF_BITS-1:0]  coef_mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0] coef_valid;
  logic                  coef_we;
  logic [7:0]            coef_wa_full;
  logic [CADDR_W-1:0]    coef_wa;
  logic                  slot_ok;

  assign coef_wa_full = {2'b00, in_stage, 2'b00} + {4'h0, in_stage} + {5'h00, in_slot};
  assign coef_wa      = CADDR_W'(coef_wa_full);
  // shelf stage keeps b2 and a2 at zero
  assign slot_ok = (in_slot <= cbq_pkg::SLOT_A2) &&
                   !((32'(in_stage) == 32'(NUM_BANDS)) &&
                     ((in_slot == cbq_pkg::SLOT_B2) || (in_slot == cbq_pkg::SLOT_A2)));
  assign coef_we = in_fire && (s_tuser == cbq_pkg::OP_WRITE) &&
                   (32'(in_stage) <= 32'(NUM_BANDS)) && slot_ok;

  // delay store: one row per stage holding {y2, y1, x2, x1}
  logic [ROW_W-1:0]      delay_mem [NUM_STAGES];
  logic [NUM_STAGES-1:0] row_valid;

  // issue sequencer: walks stages and taps, one memory read per cycle
  logic               issue_on;
  logic [STAGE_W-1:0] is_stage;
  logic [2:0]         is_seq;
  logic [CADDR_W-1:0] coef_base;
  logic [CADDR_W-1:0] coef_ra;
  assign coef_ra = coef_base + CADDR_W'(cbq_pkg::seq_slot(is_seq));

  // read stage registers
  logic                 p1_valid;
  logic [2:0]           p1_seq;
  logic [COEF_BITS-1:0] coef_q;
  logic                 coef_ok;
  logic [ROW_W-1:0]     row_q;
  logic                 row_ok;

  // product stage registers
  logic                     p2_valid;
  logic [2:0]               p2_seq;
  logic signed [PROD_W-1:0] prod;

  // accumulate stage registers
  logic                                p3_fin;
  logic signed [cbq_pkg::ACC_BITS-1:0] acc;
  logic [STAGE_W-1:0]                  wb_stage;
  logic signed [SAMPLE_BITS-1:0]       wb_x1;
  logic signed [SAMPLE_BITS-1:0]       wb_y1;

  // current stage input, becomes each stage's output in turn
  logic signed [SAMPLE_BITS-1:0] x;

  // operand selection from the delay row read
  logic signed [COEF_BITS-1:0]   coef_op;
  logic signed [SAMPLE_BITS-1:0] row_x1, row_x2, row_y1, row_y2;
  logic signed [SAMPLE_BITS-1:0] data_op;

  assign coef_op = coef_ok ? signed'(coef_q) : '0;
  assign row_x1  = row_ok ? signed'(row_q[SAMPLE_BITS-1:0])               : '0;
  assign row_x2  = row_ok ? signed'(row_q[2*SAMPLE_BITS-1:SAMPLE_BITS])   : '0;
  assign row_y1  = row_ok ? signed'(row_q[3*SAMPLE_BITS-1:2*SAMPLE_BITS]) : '0;
  assign row_y2  = row_ok ? signed'(row_q[4*SAMPLE_BITS-1:3*SAMPLE_BITS]) : '0;

  always_comb begin
    case (p1_seq)
      cbq_pkg::SEQ_X1: data_op = row_x1;
      cbq_pkg::SEQ_X2: data_op = row_x2;
      cbq_pkg::SEQ_Y1: data_op = row_y1;
      cbq_pkg::SEQ_Y2: data_op = row_y2;
      default:         data_op = x;
    endcase
  end

  // saturate the product, apply the feedback sign, accumulate with saturation
  logic signed [WIDE_W-1:0]            prod_w;
  logic signed [cbq_pkg::ACC_BITS-1:0] prod_sat;
  logic signed [cbq_pkg::ACC_BITS-1:0] term;
  logic signed [cbq_pkg::ACC_BITS-1:0] acc_base;
  logic signed [cbq_pkg::ACC_BITS-1:0] acc_next;

  always_comb begin
    prod_w = WIDE_W'(prod);
    if (prod_w > PROD_MAX) begin
      prod_sat = ACC_MAX;
    end else if (prod_w < -PROD_MAX) begin
      prod_sat = -ACC_MAX;
    end else begin
      prod_sat = cbq_pkg::ACC_BITS'(prod_w);
    end
    term     = ((p2_seq == cbq_pkg::SEQ_Y1) || (p2_seq == cbq_pkg::SEQ_Y2)) ? -prod_sat
                                                                            : prod_sat;
    acc_base = (p2_seq == cbq_pkg::SEQ_X1) ? '0 : acc;
    acc_next = sat_sum(SUM_W'(acc_base) + SUM_W'(term));
  end

  // round half up to the sample grid, then saturate to the sample width
  logic signed [SUM_W-1:0]             round_sum;
  logic signed [cbq_pkg::ACC_BITS-1:0] round_sat;
  logic signed [cbq_pkg::ACC_BITS-1:0] shifted;
  logic signed [SAMPLE_BITS-1:0]       y;

  always_comb begin
    round_sum = SUM_W'(acc) + ROUND_HALF;
    round_sat = (round_sum > SUM_MAX) ? ACC_MAX : cbq_pkg::ACC_BITS'(round_sum);
    shifted   = round_sat >>> cbq_pkg::COEF_FRAC;
    if (shifted > SMAX) begin
      y = SAMPLE_BITS'(SMAX);
    end else if (shifted < SMIN) begin
      y = SAMPLE_BITS'(SMIN);
    end else begin
      y = SAMPLE_BITS'(shifted);
    end
  end

  logic last_fin;
  logic out_free;
  logic out_load;
  assign last_fin = p3_fin && (32'(wb_stage) == 32'(NUM_STAGES - 1));
  assign out_free = !m_tvalid || m_tready;
  assign out_load = ((state == ST_RUN) && last_fin && out_free) ||
                    ((state == ST_HOLD) && out_free);

  // memories, payload only
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= COEF_BITS'(in_coef);
    end
    coef_q <= coef_mem[coef_ra];
    row_q  <= delay_mem[is_stage];
    if (p3_fin) begin
      delay_mem[wb_stage] <= {wb_y1, clamp15(y), wb_x1, clamp15(x)};
    end
  end

  // valid bits: reset reads as zero until written
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= '0;
      row_valid  <= '0;
      coef_ok    <= 1'b0;
      row_ok     <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_valid[coef_wa] <= 1'b1;
      end
      if (p3_fin) begin
        row_valid[wb_stage] <= 1'b1;
      end
      coef_ok <= coef_valid[coef_ra];
      row_ok  <= row_valid[is_stage];
    end
  end

  // sequencer and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_on  <= 1'b0;
      is_stage  <= '0;
      is_seq    <= cbq_pkg::SEQ_X1;
      coef_base <= '0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_fin    <= 1'b0;
      wb_stage  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      p1_valid <= issue_on;
      p2_valid <= p1_valid;
      p3_fin   <= p2_valid && (p2_seq == cbq_pkg::SEQ_X0);

      if (in_fire && (s_tuser == cbq_pkg::OP_FILTER)) begin
        state     <= ST_RUN;
        issue_on  <= 1'b1;
        is_stage  <= '0;
        is_seq    <= cbq_pkg::SEQ_X1;
        coef_base <= '0;
        wb_stage  <= '0;
      end else if (issue_on) begin
        if (is_seq == cbq_pkg::SEQ_X0) begin
          is_seq <= cbq_pkg::SEQ_X1;
          if (32'(is_stage) == 32'(NUM_STAGES - 1)) begin
            issue_on <= 1'b0;
          end else begin
            is_stage  <= is_stage + 1'b1;
            coef_base <= coef_base + CADDR_W'(cbq_pkg::TAP_COUNT);
          end
        end else begin
          is_seq <= is_seq + 1'b1;
        end
      end

      if (p3_fin && !last_fin) begin
        wb_stage <= wb_stage + 1'b1;
      end

      // end of the cascade: hand the result over or park it in x
      if (state == ST_RUN && last_fin) begin
        state <= out_free ? ST_IDLE : ST_HOLD;
      end else if (state == ST_HOLD && out_free) begin
        state <= ST_IDLE;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    p1_seq <= is_seq;
    p2_seq <= p1_seq;
    if (p1_valid) begin
      prod <= PROD_W'(coef_op) * PROD_W'(data_op);
    end
    // old x1 and y1 shift into x2 and y2 on writeback
    if (p1_valid && p1_seq == cbq_pkg::SEQ_X0) begin
      wb_x1 <= row_x1;
      wb_y1 <= row_y1;
    end
    if (p2_valid) begin
      acc <= acc_next;
    end
    if (in_fire && (s_tuser == cbq_pkg::OP_FILTER)) begin
      x <= in_sample;
    end else if (p3_fin) begin
      x <= y;
    end
    if (state == ST_RUN && last_fin && out_free) begin
      m_tdata <= OUT_W'($unsigned(y));
    end else if (state == ST_HOLD && out_free) begin
      m_tdata <= OUT_W'($unsigned(x));
    end
  end

`ifndef ASSERT_OFF
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output register reloaded while an item waits");

  // no new item is taken while taps are still in flight
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (issue_on || p1_valid || p2_valid || p3_fin) |-> !s_tready)
    else $error("input accepted while the cascade is running");

  // coefficient writes never collide with the sequencer reading the store
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    coef_we |-> !issue_on && !p1_valid)
    else $error("coefficient write during a filter run");

  // writeback stage follows the issue stage and stays in range
  a_wb_range: assert property (@(posedge clk) disable iff (rst)
    p3_fin |-> (32'(wb_stage) <= 32'(NUM_STAGES - 1)))
    else $error("delay writeback beyond the last stage");
`endif

endmodule
